// File: rtl/core/rcpp_pkg.sv
// ----------------------------------------------------------------------------
// rcpp_pkg
// Shared types and constants for the RTCP compound packet parser.
// ----------------------------------------------------------------------------
package rcpp_pkg;

    // RTCP payload types that get decoded
    localparam logic [7:0] PT_SR  = 8'd200;
    localparam logic [7:0] PT_RR  = 8'd201;
    localparam logic [7:0] PT_BYE = 8'd203;

    // Sub-packet layout
    localparam int unsigned SR_BASE     = 28;   // first report block byte, SR
    localparam int unsigned RR_BASE     = 8;    // first report block byte, RR
    localparam int unsigned BLOCK_BYTES = 24;   // bytes per report block
    localparam logic [31:0] LOSS_MASK   = 32'h00FF_FFFF;
    localparam logic [1:0]  RTP_VERSION = 2'd2;

    // Sub-packet verdict
    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_VER   = 3'd1,
        ST_SHORT     = 3'd2,
        ST_BYE_EMPTY = 3'd3,
        ST_OTHER     = 3'd4,
        ST_TRUNC     = 3'd5
    } t_status;

    // Decoded field identifiers
    typedef enum logic [3:0] {
        FC_SENDER_SSRC = 4'd0,
        FC_NTP         = 4'd1,
        FC_RTP_TS      = 4'd2,
        FC_PKT_COUNT   = 4'd3,
        FC_OCT_COUNT   = 4'd4,
        FC_BLK_SSRC    = 4'd5,
        FC_FRAC_LOST   = 4'd6,
        FC_CUM_LOST    = 4'd7,
        FC_HIGH_SEQ    = 4'd8,
        FC_JITTER      = 4'd9,
        FC_LAST_SR     = 4'd10,
        FC_DELAY_SR    = 4'd11,
        FC_BYE_SSRC    = 4'd12
    } t_field;

    // One result item
    typedef struct packed {
        logic [7:0]  pkt_type;
        t_field      code;
        logic [4:0]  idx;
        logic [63:0] value;
        logic        fvalid;
        logic        done;
        t_status     status;
        logic        dend;
    } t_result;

endpackage

// File: rtl/core/rcpp_parse.sv
// ----------------------------------------------------------------------------
// rcpp_parse
// Per-byte sub-packet walker: header capture, verdict, field decode and the
// parser state, updated once for each byte that steps through.
// ----------------------------------------------------------------------------
module rcpp_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_datagram,
    output rcpp_pkg::t_result o_res,
    output logic             o_has_result
);
    import rcpp_pkg::*;

    // parser state
    logic [17:0] r_off;
    logic [55:0] r_word;
    logic [7:0]  r_type;
    logic [4:0]  r_count;
    logic [15:0] r_len;
    t_status     r_verdict;
    logic [4:0]  r_blk_j;    // byte position inside report block
    logic [4:0]  r_blk_i;    // report block number, saturates at 31

    logic [17:0] n_off;
    logic [7:0]  n_type;
    logic [4:0]  n_count;
    logic [15:0] n_len;
    t_status     n_verdict;
    logic [4:0]  n_blk_j;
    logic [4:0]  n_blk_i;

    logic [63:0] w64;
    logic [31:0] w32;
    logic [18:0] pkt_len;
    logic [9:0]  min_len;
    logic [17:0] pkt_last;
    logic        is_last;
    logic [17:0] bye_off;
    logic [15:0] bye_idx;
    logic [17:0] base;
    logic [17:0] off_inc;
    logic        type_known;
    t_result     res;

    assign w64 = {r_word, i_data_byte};
    assign w32 = w64[31:0];

    // header capture and verdict
    always_comb begin
        n_type    = r_type;
        n_count   = r_count;
        n_len     = r_len;
        n_verdict = r_verdict;
        pkt_len   = ({3'b000, r_len} + 19'd1) << 2;
        min_len   = 10'd0;
        type_known = (i_data_byte == PT_SR) || (i_data_byte == PT_RR) ||
                     (i_data_byte == PT_BYE);
        if (r_off == 18'd0) begin
            n_count   = i_data_byte[4:0];
            n_verdict = (i_data_byte[7:6] != RTP_VERSION) ? ST_BAD_VER : ST_OK;
            n_type    = 8'd0;
            n_len     = 16'd0;
        end else if (r_off == 18'd1) begin
            n_type = i_data_byte;
            if (!type_known) begin
                n_verdict = ST_OTHER;
            end
        end else if (r_off == 18'd2) begin
            n_len = {i_data_byte, 8'h00};
        end else if (r_off == 18'd3) begin
            n_len   = {r_len[15:8], i_data_byte};
            pkt_len = ({3'b000, n_len} + 19'd1) << 2;
            min_len = ((r_type == PT_SR) ? 10'(SR_BASE) : 10'(RR_BASE)) +
                      {1'b0, r_count, 4'b0000} + {2'b00, r_count, 3'b000};
            if (r_verdict == ST_OK) begin
                if ((r_type == PT_SR || r_type == PT_RR) &&
                    pkt_len < {9'd0, min_len}) begin
                    n_verdict = ST_SHORT;
                end else if (r_type == PT_BYE &&
                             (r_count == 5'd0 || n_len == 16'd0)) begin
                    n_verdict = ST_BYE_EMPTY;
                end
            end
        end
    end

    // sub-packet end and offset advance
    assign pkt_last = {n_len, 2'b11};
    assign is_last  = (r_off >= 18'd3) && (r_off == pkt_last);
    assign off_inc  = r_off + 18'd1;
    assign n_off    = (is_last || i_end_of_datagram) ? 18'd0 : off_inc;

    // report block position tracking
    assign base = (n_type == PT_SR) ? 18'(SR_BASE) : 18'(RR_BASE);
    always_comb begin
        n_blk_j = r_blk_j;
        n_blk_i = r_blk_i;
        if (off_inc == base) begin
            n_blk_j = 5'd0;
            n_blk_i = 5'd0;
        end else if (r_off >= base) begin
            if (r_blk_j == 5'(BLOCK_BYTES - 1)) begin
                n_blk_j = 5'd0;
                if (r_blk_i != 5'd31) begin
                    n_blk_i = r_blk_i + 5'd1;
                end
            end else begin
                n_blk_j = r_blk_j + 5'd1;
            end
        end
    end

    // field decode
    assign bye_off = r_off - 18'd4;
    assign bye_idx = bye_off[17:2];
    always_comb begin
        res          = '0;
        res.pkt_type = n_type;
        res.code     = FC_SENDER_SSRC;
        if (r_off >= 18'd4 && r_verdict == ST_OK) begin
            if (r_type == PT_BYE) begin
                if (r_off[1:0] == 2'b11 && bye_idx < {11'd0, r_count}) begin
                    res.fvalid = 1'b1;
                    res.code   = FC_BYE_SSRC;
                    res.idx    = bye_idx[4:0];
                    res.value  = {32'd0, w32};
                end
            end else if (r_off == 18'd7) begin
                res.fvalid = 1'b1;
                res.code   = FC_SENDER_SSRC;
                res.value  = {32'd0, w32};
            end else if (r_type == PT_SR && r_off < 18'(SR_BASE)) begin
                res.value = {32'd0, w32};
                case (r_off[4:0])
                    5'd15: begin
                        res.fvalid = 1'b1;
                        res.code   = FC_NTP;
                        res.value  = w64;
                    end
                    5'd19: begin
                        res.fvalid = 1'b1;
                        res.code   = FC_RTP_TS;
                    end
                    5'd23: begin
                        res.fvalid = 1'b1;
                        res.code   = FC_PKT_COUNT;
                    end
                    5'd27: begin
                        res.fvalid = 1'b1;
                        res.code   = FC_OCT_COUNT;
                    end
                    default: res.value = 64'd0;
                endcase
            end else if (r_off >= base && r_blk_i < r_count) begin
                res.fvalid = 1'b1;
                res.idx    = r_blk_i;
                res.value  = {32'd0, w32};
                case (r_blk_j)
                    5'd3:  res.code = FC_BLK_SSRC;
                    5'd4: begin
                        res.code  = FC_FRAC_LOST;
                        res.value = {56'd0, i_data_byte};
                    end
                    5'd7: begin
                        res.code  = FC_CUM_LOST;
                        res.value = {32'd0, w32 & LOSS_MASK};
                    end
                    5'd11: res.code = FC_HIGH_SEQ;
                    5'd15: res.code = FC_JITTER;
                    5'd19: res.code = FC_LAST_SR;
                    5'd23: res.code = FC_DELAY_SR;
                    default: begin
                        res.fvalid = 1'b0;
                        res.idx    = 5'd0;
                        res.value  = 64'd0;
                    end
                endcase
            end
        end
        res.done   = is_last || i_end_of_datagram;
        res.status = is_last ? n_verdict : (i_end_of_datagram ? ST_TRUNC : ST_OK);
        res.dend   = i_end_of_datagram;
    end

    assign o_res        = res;
    assign o_has_result = res.fvalid || res.done || res.dend;

    // state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off     <= '0;
            r_word    <= '0;
            r_type    <= '0;
            r_count   <= '0;
            r_len     <= '0;
            r_verdict <= ST_OK;
            r_blk_j   <= '0;
            r_blk_i   <= '0;
        end else if (i_step) begin
            r_off     <= n_off;
            r_word    <= w64[55:0];
            r_type    <= n_type;
            r_count   <= n_count;
            r_len     <= n_len;
            r_verdict <= n_verdict;
            r_blk_j   <= n_blk_j;
            r_blk_i   <= n_blk_i;
        end
    end

endmodule

// File: rtl/core/rtcp_compound_packet_parser.sv
// ----------------------------------------------------------------------------
// rtcp_compound_packet_parser
// Walks an RTCP compound datagram byte by byte and reports SR/RR/BYE fields
// and a verdict for every sub-packet.
// ----------------------------------------------------------------------------
//  channel   handshake             payload
//  input     i_valid / o_stall     i_data_byte, i_end_of_datagram
//  output    o_valid / i_stall     o_packet_type .. o_datagram_end
//
//  One byte per cycle while the output is not stalled; a byte's result reaches
//  the outputs through the input register, then the result register.
//  Synchronous active-low reset clears the parser and the valid flags of both registers.
//  A stall on the output holds the result and the byte waiting behind it;
//  bytes that produce no result still pass through the input register.
// ----------------------------------------------------------------------------
module rtcp_compound_packet_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_datagram,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_packet_type,
    output logic [3:0]  o_field_code,
    output logic [4:0]  o_block_index,
    output logic [63:0] o_field_value,
    output logic        o_field_valid,
    output logic        o_packet_done,
    output logic [2:0]  o_packet_status,
    output logic        o_datagram_end
);
    import rcpp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_eod;
    logic       r_out_valid;
    t_result    r_out;

    logic       advance;
    logic       step;
    t_result    res;
    logic       has_result;

    // handshake
    assign advance = !r_out_valid || !i_stall;
    assign o_stall = r_in_valid && !advance;
    assign step    = r_in_valid && advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_eod  <= i_end_of_datagram;
        end
    end

    rcpp_parse u_parse (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_step            (step),
        .i_data_byte       (r_in_byte),
        .i_end_of_datagram (r_in_eod),
        .o_res             (res),
        .o_has_result      (has_result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_packet_type   = r_out.pkt_type;
    assign o_field_code    = r_out.code;
    assign o_block_index   = r_out.idx;
    assign o_field_value   = r_out.value;
    assign o_field_valid   = r_out.fvalid;
    assign o_packet_done   = r_out.done;
    assign o_packet_status = r_out.status;
    assign o_datagram_end  = r_out.dend;

endmodule
